// ===== src/khcps_pkg.sv =====
// ----------------------------------------------------------------------------
// khcps_pkg
// Types and codes shared by the kick/hold coil PWM sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package khcps_pkg;

  // Request kinds
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Side phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FWD  = 2'd1;
  localparam logic [1:0] PH_REV  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FULL_SCALE  = 2'd0;
  localparam logic [1:0] REG_KICK_LEFT   = 2'd1;
  localparam logic [1:0] REG_KICK_RIGHT  = 2'd2;

  // Configuration reset values
  localparam logic [15:0] FULL_SCALE_RST = 16'd1000;
  localparam logic [15:0] KICK_TICKS_RST = 16'd100;

  // Input item
  typedef struct packed {
    logic        req_type;
    logic [15:0] hold_left;
    logic [15:0] hold_right;
  } req_t;

  // Result item
  typedef struct packed {
    logic [15:0] left_cmp_a;
    logic [15:0] left_cmp_b;
    logic [15:0] right_cmp_a;
    logic [15:0] right_cmp_b;
    logic [1:0]  left_phase;
    logic [1:0]  right_phase;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/kick_hold_coil_pwm_sequencer.sv =====
// ----------------------------------------------------------------------------
// kick_hold_coil_pwm_sequencer
// Two-side peak-and-hold coil driver: update items latch hold levels and
// start kicks, tick items count kicks down; one result per item.
// ----------------------------------------------------------------------------
// Every item passes the input register, then the result register, and a new
// item is accepted every cycle while the result side keeps taking. The per-side
// compare, countdown and phase update is one short combinational step between
// the input register and the side state, which sets the one-item-per-clock
// rate. Configuration is written directly into the period and kick-time
// registers through the plain write port.
`default_nettype none

module kick_hold_coil_pwm_sequencer #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration
  input  wire logic             cfg_en,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  // input channel
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire khcps_pkg::req_t  in_data,
  // result channel
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      khcps_pkg::rsp_t  out_data
);

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

  // configuration registers
  logic [15:0] full_scale;
  logic [15:0] kick_ticks [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale    <= khcps_pkg::FULL_SCALE_RST;
      kick_ticks[0] <= khcps_pkg::KICK_TICKS_RST;
      kick_ticks[1] <= khcps_pkg::KICK_TICKS_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        khcps_pkg::REG_FULL_SCALE: full_scale    <= cfg_data;
        khcps_pkg::REG_KICK_LEFT:  kick_ticks[0] <= cfg_data;
        khcps_pkg::REG_KICK_RIGHT: kick_ticks[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register and pipeline handshake
  logic            s1_valid;
  khcps_pkg::req_t s1_req;
  logic            s1_go;

  assign s1_go    = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req <= in_data;
    end
  end

  // side state
  logic [1:0]            phase           [2];
  logic [COUNT_BITS-1:0] kick_count      [2];
  logic [15:0]           cmp_a           [2];
  logic [15:0]           cmp_b           [2];
  logic [15:0]           latched_hold    [2];
  logic [1:0]            phase_next      [2];
  logic [COUNT_BITS-1:0] kick_count_next [2];
  logic [15:0]           cmp_a_next      [2];
  logic [15:0]           cmp_b_next      [2];
  logic [15:0]           latched_hold_next [2];
  logic [15:0]           hold_in         [2];
  logic [COUNT_BITS-1:0] kick_load       [2];
  logic [COUNT_BITS-1:0] count_dec       [2];
  logic [31:0]           ticks_wide      [2];

  assign hold_in[0] = s1_req.hold_left;
  assign hold_in[1] = s1_req.hold_right;

  // per-side update / tick step
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      // kick load: zero counts as one, too wide saturates
      ticks_wide[s] = {16'd0, kick_ticks[s]};
      if (kick_ticks[s] == 16'd0) begin
        ticks_wide[s] = 32'd1;
      end
      if ({1'b0, ticks_wide[s]} > CNT_MAX) begin
        kick_load[s] = '1;
      end else begin
        kick_load[s] = ticks_wide[s][COUNT_BITS-1:0];
      end
      count_dec[s] = kick_count[s] - {{(COUNT_BITS-1){1'b0}}, 1'b1};

      phase_next[s]        = phase[s];
      kick_count_next[s]   = kick_count[s];
      cmp_a_next[s]        = cmp_a[s];
      cmp_b_next[s]        = cmp_b[s];
      latched_hold_next[s] = latched_hold[s];

      if (s1_req.req_type == khcps_pkg::REQ_UPDATE) begin
        latched_hold_next[s] = hold_in[s];
        if (phase[s] == khcps_pkg::PH_IDLE) begin
          if (cmp_b[s] == 16'd0) begin
            if (hold_in[s] < full_scale) begin
              // forward kick
              cmp_b_next[s]      = full_scale;
              cmp_a_next[s]      = 16'd0;
              phase_next[s]      = khcps_pkg::PH_FWD;
              kick_count_next[s] = kick_load[s];
            end
          end else if (hold_in[s] == full_scale) begin
            // reverse kick
            cmp_a_next[s]      = full_scale;
            cmp_b_next[s]      = 16'd0;
            phase_next[s]      = khcps_pkg::PH_REV;
            kick_count_next[s] = kick_load[s];
          end else if (hold_in[s] < full_scale) begin
            cmp_a_next[s] = hold_in[s];
          end
        end
      end else if (phase[s] != khcps_pkg::PH_IDLE) begin
        // countdown of an armed kick
        kick_count_next[s] = count_dec[s];
        if (count_dec[s] == '0) begin
          if (phase[s] == khcps_pkg::PH_FWD) begin
            cmp_a_next[s] = latched_hold[s];
          end
          phase_next[s] = khcps_pkg::PH_IDLE;
        end
      end
    end
  end

  logic s1_fire;
  assign s1_fire = s1_valid && s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        phase[s]        <= khcps_pkg::PH_IDLE;
        kick_count[s]   <= '0;
        cmp_a[s]        <= 16'd0;
        cmp_b[s]        <= 16'd0;
        latched_hold[s] <= 16'd0;
      end
    end else if (s1_fire) begin
      for (int s = 0; s < 2; s++) begin
        phase[s]        <= phase_next[s];
        kick_count[s]   <= kick_count_next[s];
        cmp_a[s]        <= cmp_a_next[s];
        cmp_b[s]        <= cmp_b_next[s];
        latched_hold[s] <= latched_hold_next[s];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data.left_cmp_a  <= cmp_a_next[0];
      out_data.left_cmp_b  <= cmp_b_next[0];
      out_data.right_cmp_a <= cmp_a_next[1];
      out_data.right_cmp_b <= cmp_b_next[1];
      out_data.left_phase  <= phase_next[0];
      out_data.right_phase <= phase_next[1];
    end
  end

`ifndef SYNTHESIS
  // an armed kick always has time left to run
  a_left_armed_count: assert property (@(posedge clk) disable iff (rst)
    (phase[0] != khcps_pkg::PH_IDLE) |-> (kick_count[0] != '0))
    else $error("left kick armed with zero count");

  a_right_armed_count: assert property (@(posedge clk) disable iff (rst)
    (phase[1] != khcps_pkg::PH_IDLE) |-> (kick_count[1] != '0))
    else $error("right kick armed with zero count");

  // a left-side reverse kick keeps the second compare at zero
  a_rev_b_zero: assert property (@(posedge clk) disable iff (rst)
    (phase[0] == khcps_pkg::PH_REV) |-> (cmp_b[0] == 16'd0))
    else $error("left reverse kick with non-zero second compare");

  // a registered item reaches an empty result register in the next cycle
  a_item_advances: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("item lost between input and result register");
`endif

endmodule

`default_nettype wire
